@@ hdl/alg_pkg.sv @@
`default_nettype none
package alg_pkg;

  localparam int unsigned DEG_LIMIT = 8;
  localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [63:0] VAL_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] VAL_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } sval_t;

  // signed result from sign and magnitude, clamped to the 64-bit range
  function automatic sval_t clamp_mag(input logic neg, input logic [68:0] mag);
    sval_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > 69'(VAL_MAX)) begin
        r.val = VAL_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = mag[63:0];
      end
    end else begin
      if (mag > {5'd0, 1'b1, 63'd0}) begin
        r.val = VAL_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = 64'(-mag);
      end
    end
    return r;
  endfunction

  function automatic sval_t mul_small(input logic signed [63:0] v, input logic [4:0] k);
    logic [63:0] a;
    logic [68:0] p;
    a = v[63] ? 64'(-v) : 64'(v);
    p = 69'(a) * 69'(k);
    return clamp_mag(v[63] && (k != 5'd0), p);
  endfunction

endpackage
`default_nettype wire

@@ hdl/associated_legendre_eval_core.sv @@
// Evaluates the unnormalized associated Legendre function P_l^m(x), with the
// Condon-Shortley sign, for l up to 8, from a Q1.30 argument to a saturated
// Q39.24 value. One word is taken at a time; s_tready is high only while the
// sequencer is idle. An item with m > 0 first forms 1 - x^2 on the shared
// 32x31 multiplier and runs a square root, then each seed step and the
// first-order step run on the shared multiplier and small-integer scaler,
// and each recurrence step uses both and then waits on the two-bit-per-cycle
// divider. Out-of-domain items go straight to the result stage. The result
// register lets the next word be taken while a result waits.
`default_nettype none
module associated_legendre_eval_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // degree[3:0], order[7:4], arg_x[39:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // legendre_value[63:0]
  output logic [1:0]       m_tuser    // out_of_domain[0], saturated[1]
);
  import alg_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_SQ   = 12'b000000000010,
    ST_SQW  = 12'b000000000100,
    ST_MLO  = 12'b000000001000,
    ST_MHI  = 12'b000000010000,
    ST_MQ   = 12'b000000100000,
    ST_MK   = 12'b000001000000,
    ST_MB   = 12'b000010000000,
    ST_SUB  = 12'b000100000000,
    ST_DV   = 12'b001000000000,
    ST_DVW  = 12'b010000000000,
    ST_DONE = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_SEED = 2'd0,
    PH_P1   = 2'd1,
    PH_REC  = 2'd2
  } phase_t;

  state_t state;
  phase_t phase;

  logic [3:0]         deg;
  logic [3:0]         ord;
  logic signed [31:0] x;
  logic [30:0]        s;
  logic [4:0]         cnt;
  logic signed [63:0] pmm, pmmp1, t, a_reg, b_reg, dsub, res;
  logic [62:0]        plo, phi;
  logic               sat, ood, dneg;
  logic               ovalid;
  logic [63:0]        oval;
  logic [1:0]         ouser;

  logic [3:0]         in_deg, in_ord;
  logic signed [31:0] in_x;
  logic               bad;

  logic signed [63:0] v_op;
  logic [63:0]        v_mag;
  logic signed [31:0] y_op;
  logic [30:0]        y_mag;
  logic [31:0]        mul_a;
  logic [62:0]        prod;
  logic [64:0]        rq;
  sval_t              qv;
  logic signed [63:0] sm_v;
  logic [4:0]         sm_k, k_odd, kb;
  sval_t              sm;
  logic signed [63:0] seed_val;
  logic               seed_sat;
  logic signed [64:0] diff;
  logic [63:0]        dmag;
  logic [3:0]         kdiv;

  logic        sq_start, sq_done;
  logic [60:0] sq_n;
  logic [30:0] sq_root;
  logic        dv_start, dv_done;
  logic [63:0] dv_n, dv_q;
  sval_t       dq;

  assign in_deg = s_tdata[3:0];
  assign in_ord = s_tdata[7:4];
  assign in_x   = s_tdata[39:8];
  assign bad    = (in_ord > in_deg) || (in_deg > 4'(DEG_LIMIT)) ||
                  (in_x > ONE_Q30) || (in_x < -ONE_Q30);

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    v_op  = (phase == PH_REC) ? pmmp1 : pmm;
    v_mag = v_op[63] ? 64'(-v_op) : 64'(v_op);
    // x^2 for the square root radicand goes through the same multiplier
    y_op  = (phase == PH_SEED && state != ST_SQ) ? {1'b0, s} : x;
    y_mag = y_op[31] ? 31'(-y_op) : y_op[30:0];
    mul_a = (state == ST_MLO) ? v_mag[31:0] :
            (state == ST_SQ)  ? {1'b0, y_mag} : v_mag[63:32];
    prod  = 63'(mul_a) * 63'(y_mag);
    // round(v*y/2^30), ties away from zero, on magnitudes
    rq    = {phi, 2'b00} + 65'((plo + 63'(64'd1 << 29)) >> 30);
    qv    = clamp_mag(v_op[63] ^ y_op[31], 69'(rq));
    k_odd = (phase == PH_P1) ? {ord, 1'b1} : 5'({cnt[3:0], 1'b0} - 5'd1);
    kb    = 5'(cnt + 5'(ord) - 5'd1);
    sm_v  = (state == ST_MB) ? pmm : t;
    sm_k  = (state == ST_MB) ? kb : k_odd;
    sm    = mul_small(sm_v, sm_k);
    seed_sat = (sm.val == VAL_MIN);
    seed_val = seed_sat ? VAL_MAX : 64'(-sm.val);
    diff  = {a_reg[63], a_reg} - {b_reg[63], b_reg};
    dmag  = dsub[63] ? 64'(-dsub) : 64'(dsub);
    kdiv  = 4'(cnt - 5'(ord));
    dv_n  = dmag + 64'(kdiv >> 1);
    dq    = clamp_mag(dneg, 69'(dv_q));
    sq_n  = 61'((63'd1 << 60) - prod);
  end

  assign sq_start = (state == ST_SQ);
  assign dv_start = (state == ST_DV);

  alg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_n),
    .done     (sq_done),
    .root     (sq_root)
  );

  alg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_n),
    .divisor  (kdiv),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      phase  <= PH_SEED;
      ovalid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!ovalid || m_tready)) begin
        ovalid <= 1'b1;
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            deg   <= in_deg;
            ord   <= in_ord;
            x     <= in_x;
            sat   <= 1'b0;
            pmm   <= ONE_Q24;
            cnt   <= 5'd1;
            phase <= PH_SEED;
            ood   <= bad;
            if (bad) begin
              res   <= '0;
              state <= ST_DONE;
            end else if (in_ord != 4'd0) begin
              state <= ST_SQ;
            end else if (in_deg == 4'd0) begin
              res   <= ONE_Q24;
              state <= ST_DONE;
            end else begin
              phase <= PH_P1;
              state <= ST_MLO;
            end
          end
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: begin
          if (sq_done) begin
            s     <= sq_root;
            state <= ST_MLO;
          end
        end
        ST_MLO: begin
          plo   <= prod;
          state <= ST_MHI;
        end
        ST_MHI: begin
          phi   <= prod;
          state <= ST_MQ;
        end
        ST_MQ: begin
          t     <= qv.val;
          sat   <= sat | qv.sat;
          state <= ST_MK;
        end
        ST_MK: begin
          unique case (phase)
            PH_SEED: begin
              pmm <= seed_val;
              sat <= sat | sm.sat | seed_sat;
              if (cnt == 5'(ord)) begin
                if (deg == ord) begin
                  res   <= seed_val;
                  state <= ST_DONE;
                end else begin
                  phase <= PH_P1;
                  state <= ST_MLO;
                end
              end else begin
                cnt   <= cnt + 5'd1;
                state <= ST_MLO;
              end
            end
            PH_P1: begin
              pmmp1 <= sm.val;
              res   <= sm.val;
              sat   <= sat | sm.sat;
              cnt   <= 5'(ord) + 5'd2;
              if (5'(ord) + 5'd2 > 5'(deg)) begin
                state <= ST_DONE;
              end else begin
                phase <= PH_REC;
                state <= ST_MLO;
              end
            end
            default: begin
              a_reg <= sm.val;
              sat   <= sat | sm.sat;
              state <= ST_MB;
            end
          endcase
        end
        ST_MB: begin
          b_reg <= sm.val;
          sat   <= sat | sm.sat;
          state <= ST_SUB;
        end
        ST_SUB: begin
          if (diff[64] != diff[63]) begin
            dsub <= diff[64] ? VAL_MIN : VAL_MAX;
            sat  <= 1'b1;
          end else begin
            dsub <= diff[63:0];
          end
          state <= ST_DV;
        end
        ST_DV: begin
          dneg  <= dsub[63];
          state <= ST_DVW;
        end
        ST_DVW: begin
          if (dv_done) begin
            res   <= dq.val;
            sat   <= sat | dq.sat;
            pmm   <= pmmp1;
            pmmp1 <= dq.val;
            if (cnt == 5'(deg)) begin
              state <= ST_DONE;
            end else begin
              cnt   <= cnt + 5'd1;
              state <= ST_MLO;
            end
          end
        end
        ST_DONE: begin
          if (!ovalid || m_tready) begin
            oval  <= res;
            ouser <= {sat & ~ood, ood};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = oval;
  assign m_tuser  = ouser;
endmodule
`default_nettype wire

@@ hdl/alg_sqrt.sv @@
`default_nettype none
module alg_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [60:0] radicand,
  output logic             done,
  output logic [30:0]      root
);
  logic [61:0] num;
  logic [61:0] acc;
  logic [4:0]  idx;
  logic        busy;
  logic [61:0] bitv;
  logic [61:0] trial;

  // one result bit per cycle
  always_comb begin
    bitv  = 62'(1) << {idx, 1'b0};
    trial = acc + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= {1'b0, radicand};
        acc  <= '0;
        idx  <= 5'd30;
      end else if (busy) begin
        if (num >= trial) begin
          num <= num - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        idx <= idx - 5'd1;
        if (idx == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = acc[30:0];
endmodule
`default_nettype wire

@@ hdl/alg_div.sv @@
`default_nettype none
module alg_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [3:0]  divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] q;
  logic [3:0]  rem;
  logic [3:0]  dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] q_next;
  logic [3:0]  rem_next;

  // restoring division, two quotient bits per cycle
  always_comb begin
    logic [4:0] r5;
    q_next   = q;
    rem_next = rem;
    for (int j = 0; j < 2; j++) begin
      r5 = {rem_next, q_next[63]};
      if (r5 >= {1'b0, dsr}) begin
        rem_next = 4'(r5 - {1'b0, dsr});
        q_next   = {q_next[62:0], 1'b1};
      end else begin
        rem_next = r5[3:0];
        q_next   = {q_next[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= 5'd31;
      end else if (busy) begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;
endmodule
`default_nettype wire

@@ hdl/alg_checker.sv @@
`default_nettype none
module alg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  // a held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // out-of-domain results are zero and never flagged saturated
  a_ood: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
    else $error("out-of-domain result not cleared");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
endmodule

bind associated_legendre_eval_core alg_checker u_alg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
